### sv/nfpid_pkg.sv
package nfpid_pkg;

    localparam logic [1:0] ACT_TRACK = 2'd0;
    localparam logic [1:0] ACT_ERROR = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [2:0] CFG_KP    = 3'd0;
    localparam logic [2:0] CFG_KI    = 3'd1;
    localparam logic [2:0] CFG_KD    = 3'd2;
    localparam logic [2:0] CFG_ILIM  = 3'd3;
    localparam logic [2:0] CFG_FEXP  = 3'd4;
    localparam logic [2:0] CFG_DELTA = 3'd5;
    localparam logic [2:0] CFG_INV   = 3'd6;
    localparam logic [2:0] CFG_ALPHA = 3'd7;

    localparam logic [47:0] ALPHA_RESET = 48'h8000_8000_8000;

    typedef enum logic [5:0] {
        OP_NOP, OP_LATCH, OP_LOAD_INT, OP_CLR_INT, OP_FT_ZERO, OP_FT_LOAD,
        OP_M_FT, OP_FT_UPD, OP_X, OP_FIRST, OP_M_FE, OP_FE_UPD, OP_M_RAW,
        OP_RAW, OP_M_FD, OP_FD_UPD, OP_INT_ZERO, OP_M_INT, OP_INT_UPD,
        OP_M_P, OP_P, OP_M_D, OP_D, OP_FAL_SET_P, OP_FAL_SET_D, OP_FAL_ZERO,
        OP_NORM_LOAD, OP_NORM, OP_LOG, OP_M_EXP, OP_EXP, OP_M_SCALE,
        OP_SCALE, OP_SUM
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_WAIT, S_FT_UPD, S_X, S_FIRST, S_MFE, S_FE_UPD,
        S_MRAW, S_RAW, S_MFD, S_FD_UPD, S_INT, S_INT_UPD, S_PSEL, S_FAL0,
        S_NORM, S_MEXP, S_EXP, S_MSCALE, S_SCALE, S_FAL_MUL, S_P, S_DSEL,
        S_D, S_SUM
    } t_state;

    typedef struct packed {
        logic       first;
        logic [1:0] act;
        logic       inv_zero;
        logic       ki_zero;
        logic       int_go;
        logic       fal_zero;
        logic       norm_done;
    } t_status;

    function automatic logic signed [31:0] sat32_f(input logic signed [67:0] v);
        if (v > 68'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -68'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_f(input logic signed [67:0] v,
                                                   input logic [30:0] lim);
        logic signed [67:0] l;
        logic signed [67:0] nl;
        l  = $signed({37'd0, lim});
        nl = -l;
        if (v > l)
            return l[31:0];
        else if (v < nl)
            return nl[31:0];
        else
            return v[31:0];
    endfunction

    // log2(1 + idx/2^bits), 16 fraction bits, by repeated squaring
    function automatic logic [15:0] log_frac_f(input int idx, input int bits);
        logic [63:0] m;
        logic [15:0] r;
        m = (64'd1 << 30) + (64'(idx) << (30 - bits));
        r = '0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            r = {r[14:0], 1'b0};
            if (m >= (64'd1 << 31)) begin
                r[0] = 1'b1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] isqrt_f(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > n)
                b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(j/2^bits) in Q1.30
    function automatic logic [31:0] exp_mant_f(input int j, input int bits);
        logic [63:0] c;
        logic [63:0] mant;
        c    = isqrt_f(64'd1 << 61);
        mant = 64'd1 << 30;
        for (int k = 1; k <= bits; k++) begin
            if (((j >> (bits - k)) & 1) != 0)
                mant = (mant * c) >> 30;
            c = isqrt_f(c << 30);
        end
        return mant[31:0];
    endfunction

endpackage

### sv/nfpid_ctrl.sv
module nfpid_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  nfpid_pkg::t_status i_status,
    output nfpid_pkg::t_op     o_op
);
    import nfpid_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_isd, n_isd;
    logic   r_ovalid, n_ovalid;
    logic   out_free;

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_isd    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_isd    <= n_isd;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_isd    = r_isd;
        n_ovalid = r_ovalid && !i_out_ready;
        o_op     = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LATCH;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.act)
                    ACT_LOAD: begin
                        o_op    = OP_LOAD_INT;
                        n_state = S_SUM;
                    end
                    ACT_CLEAR: begin
                        o_op    = OP_CLR_INT;
                        n_state = S_SUM;
                    end
                    ACT_ERROR: begin
                        o_op    = OP_FT_ZERO;
                        n_state = S_X;
                    end
                    default: begin
                        if (i_status.first) begin
                            o_op    = OP_FT_LOAD;
                            n_state = S_X;
                        end else begin
                            o_op    = OP_M_FT;
                            n_ret   = S_FT_UPD;
                            n_state = S_WAIT;
                        end
                    end
                endcase
            end
            S_WAIT: n_state = r_ret;
            S_FT_UPD: begin
                o_op    = OP_FT_UPD;
                n_state = S_X;
            end
            S_X: begin
                o_op    = OP_X;
                n_state = i_status.first ? S_FIRST : S_MFE;
            end
            S_FIRST: begin
                o_op    = OP_FIRST;
                n_state = S_INT;
            end
            S_MFE: begin
                o_op    = OP_M_FE;
                n_ret   = S_FE_UPD;
                n_state = S_WAIT;
            end
            S_FE_UPD: begin
                o_op    = OP_FE_UPD;
                n_state = i_status.inv_zero ? S_INT : S_MRAW;
            end
            S_MRAW: begin
                o_op    = OP_M_RAW;
                n_ret   = S_RAW;
                n_state = S_WAIT;
            end
            S_RAW: begin
                o_op    = OP_RAW;
                n_state = S_MFD;
            end
            S_MFD: begin
                o_op    = OP_M_FD;
                n_ret   = S_FD_UPD;
                n_state = S_WAIT;
            end
            S_FD_UPD: begin
                o_op    = OP_FD_UPD;
                n_state = S_INT;
            end
            S_INT: begin
                if (i_status.ki_zero) begin
                    o_op    = OP_INT_ZERO;
                    n_state = S_PSEL;
                end else if (i_status.int_go) begin
                    o_op    = OP_M_INT;
                    n_ret   = S_INT_UPD;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_PSEL;
                end
            end
            S_INT_UPD: begin
                o_op    = OP_INT_UPD;
                n_state = S_PSEL;
            end
            S_PSEL: begin
                if (i_status.act == ACT_ERROR) begin
                    o_op    = OP_M_P;
                    n_ret   = S_P;
                    n_state = S_WAIT;
                end else begin
                    o_op    = OP_FAL_SET_P;
                    n_isd   = 1'b0;
                    n_state = S_FAL0;
                end
            end
            S_FAL0: begin
                if (i_status.fal_zero) begin
                    o_op    = OP_FAL_ZERO;
                    n_state = S_FAL_MUL;
                end else begin
                    o_op    = OP_NORM_LOAD;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (i_status.norm_done) begin
                    o_op    = OP_LOG;
                    n_state = S_MEXP;
                end else begin
                    o_op = OP_NORM;
                end
            end
            S_MEXP: begin
                o_op    = OP_M_EXP;
                n_ret   = S_EXP;
                n_state = S_WAIT;
            end
            S_EXP: begin
                o_op    = OP_EXP;
                n_state = S_MSCALE;
            end
            S_MSCALE: begin
                o_op    = OP_M_SCALE;
                n_ret   = S_SCALE;
                n_state = S_WAIT;
            end
            S_SCALE: begin
                o_op    = OP_SCALE;
                n_state = S_FAL_MUL;
            end
            S_FAL_MUL: begin
                o_op    = r_isd ? OP_M_D : OP_M_P;
                n_ret   = r_isd ? S_D : S_P;
                n_state = S_WAIT;
            end
            S_P: begin
                o_op    = OP_P;
                n_state = S_DSEL;
            end
            S_DSEL: begin
                if (i_status.act == ACT_ERROR) begin
                    o_op    = OP_M_D;
                    n_ret   = S_D;
                    n_state = S_WAIT;
                end else begin
                    o_op    = OP_FAL_SET_D;
                    n_isd   = 1'b1;
                    n_state = S_FAL0;
                end
            end
            S_D: begin
                o_op    = OP_D;
                n_state = S_SUM;
            end
            S_SUM: begin
                if (out_free) begin
                    o_op     = OP_SUM;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### sv/nfpid_datapath.sv
module nfpid_datapath #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [47:0]         i_cfg_data,
    input  logic [1:0]          i_action,
    input  logic signed [31:0]  i_target,
    input  logic signed [31:0]  i_measurement,
    input  logic signed [31:0]  i_error_in,
    input  logic signed [31:0]  i_integrator_value,
    input  logic                i_output_limited,
    input  nfpid_pkg::t_op      i_op,
    output nfpid_pkg::t_status  o_status,
    output logic signed [31:0]  o_control_output,
    output logic signed [31:0]  o_p_term,
    output logic signed [31:0]  o_i_term,
    output logic signed [31:0]  o_d_term
);
    import nfpid_pkg::*;

    localparam int TabN = 1 << LOG_TABLE_BITS;

    logic [15:0] log_tab [TabN];
    logic [31:0] exp_tab [TabN];

    for (genvar gj = 0; gj < TabN; gj++) begin : g_tab
        assign log_tab[gj] = log_frac_f(gj, LOG_TABLE_BITS);
        assign exp_tab[gj] = exp_mant_f(gj, LOG_TABLE_BITS);
    end

    // configuration
    logic [31:0] r_kp, r_ki, r_kd, r_fexp, r_inv;
    logic [30:0] r_ilim, r_delta;
    logic [47:0] r_alpha;

    // loop state
    logic signed [31:0] r_ft, r_fe, r_fd, r_int;
    logic               r_first;

    // latched word and work registers
    logic [1:0]         r_act;
    logic signed [31:0] r_tgt, r_meas, r_ein, r_ival;
    logic               r_lim;
    logic signed [31:0] r_x, r_last, r_raw, r_p, r_d, r_fal;
    logic               r_fneg;
    logic [31:0]        r_fmag, r_sval, r_nv;
    logic signed [16:0] r_fa;
    logic [4:0]         r_np, r_nsh;
    logic signed [20:0] r_log;
    logic signed [23:0] r_e;
    logic signed [31:0] r_oc, r_op, r_oi, r_od;

    // shared multiplier
    logic [64:0]        r_pmag;
    logic               r_pneg;
    logic [4:0]         r_psh;
    logic signed [66:0] r_mres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_ilim  <= '0;
            r_fexp  <= '0;
            r_delta <= '0;
            r_inv   <= '0;
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:    r_kp    <= i_cfg_data[31:0];
                CFG_KI:    r_ki    <= i_cfg_data[31:0];
                CFG_KD:    r_kd    <= i_cfg_data[31:0];
                CFG_ILIM:  r_ilim  <= i_cfg_data[30:0];
                CFG_FEXP:  r_fexp  <= i_cfg_data[31:0];
                CFG_DELTA: r_delta <= i_cfg_data[30:0];
                CFG_INV:   r_inv   <= i_cfg_data[31:0];
                CFG_ALPHA: r_alpha <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // operand select
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic [4:0]         mul_sh;
    logic [33:0]        amag;
    logic [32:0]        bmag;
    logic [LOG_TABLE_BITS-1:0] eidx, lidx;

    assign eidx = r_e[15 -: LOG_TABLE_BITS];
    assign lidx = r_nv[30 -: LOG_TABLE_BITS];

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = 5'd0;
        case (i_op)
            OP_M_FT: begin
                mul_a  = 34'(r_tgt) - 34'(r_ft);
                mul_b  = $signed({17'd0, r_alpha[15:0]});
                mul_sh = 5'd15;
            end
            OP_M_FE: begin
                mul_a  = 34'(r_x) - 34'(r_fe);
                mul_b  = $signed({17'd0, r_alpha[31:16]});
                mul_sh = 5'd15;
            end
            OP_M_RAW: begin
                mul_a  = 34'(r_fe) - 34'(r_last);
                mul_b  = $signed({1'b0, r_inv});
                mul_sh = 5'd16;
            end
            OP_M_FD: begin
                mul_a  = 34'(r_raw) - 34'(r_fd);
                mul_b  = $signed({17'd0, r_alpha[47:32]});
                mul_sh = 5'd15;
            end
            OP_M_INT: begin
                mul_a  = 34'(r_fe);
                mul_b  = $signed({1'b0, r_ki});
                mul_sh = 5'd28;
            end
            OP_M_P: begin
                mul_a  = (r_act == ACT_TRACK) ? 34'(r_fal) : 34'(r_fe);
                mul_b  = $signed({1'b0, r_kp});
                mul_sh = 5'd16;
            end
            OP_M_D: begin
                mul_a  = (r_act == ACT_TRACK) ? 34'(r_fal) : 34'(r_fd);
                mul_b  = $signed({1'b0, r_kd});
                mul_sh = 5'd16;
            end
            OP_M_EXP: begin
                mul_a  = 34'(r_fa);
                mul_b  = 33'(r_log);
                mul_sh = 5'd14;
            end
            OP_M_SCALE: begin
                mul_a  = $signed({2'b00, r_sval});
                mul_b  = $signed({1'b0, exp_tab[eidx]});
                mul_sh = 5'd0;
            end
            default: ;
        endcase
        amag = mul_a[33] ? 34'(-mul_a) : 34'(mul_a);
        bmag = mul_b[32] ? 33'(-mul_b) : 33'(mul_b);
    end

    // magnitude product registered, then floor shift in the next cycle
    logic [65:0] rmask, rq;
    assign rmask = (66'd1 << r_psh) - 66'd1;
    assign rq    = r_pneg ? ((66'(r_pmag) + rmask) >> r_psh) : (66'(r_pmag) >> r_psh);

    always_ff @(posedge i_clk) begin
        r_pmag <= 65'(amag[32:0]) * 65'(bmag[31:0]);
        r_pneg <= mul_a[33] ^ mul_b[32];
        r_psh  <= mul_sh;
        r_mres <= r_pneg ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    end

    // 2^E scaling of the product with saturation
    logic [63:0]        prod, rsh, lsh;
    logic signed [8:0]  sc;
    logic [8:0]         rs;
    logic [30:0]        smag;
    logic [31:0]        xsel;
    logic               band;

    assign prod = r_mres[63:0];
    assign sc   = 9'($signed(r_e[23:16])) - 9'sd30;
    assign rs   = 9'(-sc);
    assign rsh  = prod >> rs[6:0];
    assign lsh  = prod << sc[4:0];
    assign band = r_fmag <= {1'b0, r_delta};

    always_comb begin
        if (!sc[8]) begin
            if (sc >= 9'sd32 || (prod >> (5'd31 - sc[4:0])) != 64'd0)
                smag = '1;
            else
                smag = lsh[30:0];
        end else begin
            smag = (rsh[63:31] != '0) ? '1 : rsh[30:0];
        end
    end

    assign xsel = (i_op == OP_FAL_SET_D) ? r_fd : r_fe;

    logic signed [67:0] mres_x;
    assign mres_x = 68'(r_mres);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ft    <= '0;
            r_fe    <= '0;
            r_fd    <= '0;
            r_int   <= '0;
            r_first <= 1'b1;
        end else begin
            case (i_op)
                OP_LOAD_INT: r_int <= clamp_f(68'(r_ival), r_ilim);
                OP_CLR_INT:  r_int <= '0;
                OP_FT_ZERO:  r_ft  <= '0;
                OP_FT_LOAD:  r_ft  <= r_tgt;
                OP_FT_UPD:   r_ft  <= sat32_f(68'(r_ft) + mres_x);
                OP_FIRST: begin
                    r_fe    <= r_x;
                    r_fd    <= '0;
                    r_first <= 1'b0;
                end
                OP_FE_UPD:   r_fe  <= sat32_f(68'(r_fe) + mres_x);
                OP_FD_UPD:   r_fd  <= sat32_f(68'(r_fd) + mres_x);
                OP_INT_ZERO: r_int <= '0;
                OP_INT_UPD:  r_int <= clamp_f(68'(r_int) + mres_x, r_ilim);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LATCH: begin
                r_act  <= i_action;
                r_tgt  <= i_target;
                r_meas <= i_measurement;
                r_ein  <= i_error_in;
                r_ival <= i_integrator_value;
                r_lim  <= i_output_limited;
            end
            OP_LOAD_INT, OP_CLR_INT: begin
                r_p <= '0;
                r_d <= '0;
            end
            OP_X: r_x <= (r_act == ACT_TRACK) ? sat32_f(68'(r_ft) - 68'(r_meas)) : r_ein;
            OP_FE_UPD: r_last <= r_fe;
            OP_RAW: r_raw <= sat32_f(mres_x);
            OP_P: r_p <= sat32_f(mres_x);
            OP_D: r_d <= sat32_f(mres_x);
            OP_FAL_SET_P, OP_FAL_SET_D: begin
                r_fneg <= xsel[31];
                r_fmag <= xsel[31] ? 32'(-xsel) : xsel;
                r_fa   <= (i_op == OP_FAL_SET_D) ? $signed({1'b0, r_fexp[31:16]})
                                                 : $signed({1'b0, r_fexp[15:0]});
            end
            OP_FAL_ZERO: r_fal <= '0;
            OP_NORM_LOAD: begin
                r_nv   <= band ? {1'b0, r_delta} : r_fmag;
                r_sval <= band ? r_fmag : 32'h0001_0000;
                r_fa   <= band ? (r_fa - 17'sd16384) : r_fa;
                r_np   <= 5'd31;
                r_nsh  <= 5'd16;
            end
            OP_NORM: begin
                // binary search for the leading one
                if ((r_nv >> (6'd32 - 6'(r_nsh))) == 32'd0) begin
                    r_nv <= r_nv << r_nsh;
                    r_np <= r_np - r_nsh;
                end
                r_nsh <= r_nsh >> 1;
            end
            OP_LOG: r_log <= $signed({5'(6'(r_np) - 6'd16), log_tab[lidx]});
            OP_EXP: r_e <= r_mres[23:0];
            OP_SCALE: r_fal <= r_fneg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
            OP_SUM: begin
                r_oc <= sat32_f(68'(r_p) + 68'(r_int) + 68'(r_d));
                r_op <= r_p;
                r_oi <= r_int;
                r_od <= r_d;
            end
            default: ;
        endcase
    end

    assign o_status.first     = r_first;
    assign o_status.act       = r_act;
    assign o_status.inv_zero  = (r_inv == 32'd0);
    assign o_status.ki_zero   = (r_ki == 32'd0);
    assign o_status.int_go    = !r_lim || (r_int > 0 && r_fe < 0) || (r_int < 0 && r_fe > 0);
    assign o_status.fal_zero  = (r_fmag == 32'd0);
    assign o_status.norm_done = (r_nsh == 5'd0);

    assign o_control_output = r_oc;
    assign o_p_term         = r_op;
    assign o_i_term         = r_oi;
    assign o_d_term         = r_od;

endmodule

### sv/nonlinear_fal_pid_controller.sv
// one word is taken at a time: the input is ready only while the sequencer is idle;
// an integrator load or clear is quickest, an error update slower, and a
// target/measurement update slowest, as it adds the two fal evaluations
// the pace is set by the single shared multiplier
// and the 5-step leading-one search in each fal evaluation of a nonzero input; slower while a result waits
// reset: synchronous active low; filters and integrator zero, first sample pending
module nonlinear_fal_pid_controller #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [47:0]   i_cfg_data,
    // sample stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // target, measurement, error_in, integrator_value, output_limited, zero pad
    input  logic [135:0]  s_axis_tdata,
    // action
    input  logic [1:0]    s_axis_tuser,
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // control_output, p_term, i_term, d_term
    output logic [127:0]  m_axis_tdata
);
    import nfpid_pkg::*;

    t_status            status;
    t_op                op;
    logic signed [31:0] ctl, pt, it, dt;

    // sequencer: one micro-op per cycle unless a result waits; multiplies add a wait state
    nfpid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_op        (op)
    );

    // filters, integrator, fal tables and the shared multiplier
    nfpid_datapath #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_action           (s_axis_tuser),
        .i_target           (s_axis_tdata[31:0]),
        .i_measurement      (s_axis_tdata[63:32]),
        .i_error_in         (s_axis_tdata[95:64]),
        .i_integrator_value (s_axis_tdata[127:96]),
        .i_output_limited   (s_axis_tdata[128]),
        .i_op               (op),
        .o_status           (status),
        .o_control_output   (ctl),
        .o_p_term           (pt),
        .o_i_term           (it),
        .o_d_term           (dt)
    );

    // result word held in the datapath output registers until taken
    assign m_axis_tdata = {dt, it, pt, ctl};

endmodule

### tb/nfpid_checker.sv
`timescale 1ns / 1ps

module nfpid_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [47:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,
    input  logic [1:0]    s_axis_tuser,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [127:0]  m_axis_tdata,
    output int            o_fail_cnt,
    output int            o_pending
);
    import nfpid_pkg::*;

    localparam int TBITS = 8;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct {
        logic [31:0] u;
        logic [31:0] p;
        logic [31:0] i;
        logic [31:0] d;
    } t_ctrl_word;

    t_ctrl_word ctrl_q[$];

    bit [63:0] log_tab[1 << TBITS];
    bit [63:0] mant_tab[1 << TBITS];

    // register copies
    bit [63:0] kp, ki_dt, kd, i_lim, f_exp, band, inv_dt, alphas;
    // loop state
    longint flt_tgt, flt_err, flt_der, integ;
    bit     first_pending;

    function automatic longint sat32(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // floor(a * g / 2^sh)
    function automatic longint mul_fl(longint a, bit [63:0] g, int sh);
        bit [63:0] mag;
        bit [63:0] prod;
        mag  = (a < 0) ? 64'(-(a + 1)) + 64'd1 : 64'(a);
        prod = mag * g;
        if (a < 0)
            return -longint'((prod + ((64'd1 << sh) - 64'd1)) >> sh);
        return longint'(prod >> sh);
    endfunction

    function automatic longint lowpass(longint y, longint x, bit [63:0] alpha);
        return sat32(y + mul_fl(x - y, alpha, 15));
    endfunction

    function automatic bit [63:0] sqrt_floor(bit [63:0] n);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 of a Q16.16 magnitude, Q.16 result
    function automatic longint log2_q16(bit [63:0] v);
        int p;
        int idx;
        p = 31;
        while (p > 0 && v[p] == 1'b0) p--;
        if (p >= TBITS)
            idx = int'((v >> (p - TBITS)) & ((1 << TBITS) - 1));
        else
            idx = int'((v << (TBITS - p)) & ((1 << TBITS) - 1));
        return longint'(p - 16) * 65536 + longint'(log_tab[idx]);
    endfunction

    function automatic longint pow2_mul(bit [63:0] mag, longint e);
        longint ei;
        longint ef;
        longint s;
        bit [63:0] prod;
        bit [63:0] v;
        ei   = e >>> 16;
        ef   = e - ei * 65536;
        prod = mag * mant_tab[int'((ef >> (16 - TBITS)) & ((1 << TBITS) - 1))];
        s    = ei - 30;
        if (s >= 0) begin
            if (s >= 32 || prod > (64'(SMAX) >> s)) return SMAX;
            return longint'(prod << s);
        end
        if (-s >= 63) return 0;
        v = prod >> (-s);
        return (v > 64'(SMAX)) ? SMAX : longint'(v);
    endfunction

    function automatic longint fal_fn(longint x, bit [63:0] a, bit [63:0] delta);
        bit [63:0] mag;
        longint m;
        mag = (x < 0) ? 64'(-x) : 64'(x);
        if (mag == 0) return 0;
        if (mag <= delta)
            m = pow2_mul(mag, ((longint'(a) - 16384) * log2_q16(delta)) >>> 14);
        else
            m = pow2_mul(64'd65536, (longint'(a) * log2_q16(mag)) >>> 14);
        return (x < 0) ? -m : m;
    endfunction

    function automatic longint lim_clamp(longint v);
        longint l;
        l = longint'(i_lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    // table build, same recipe as the block's tables
    initial begin
        bit [63:0] m;
        bit [63:0] r;
        bit [63:0] c;
        bit [63:0] mt;
        for (int j = 0; j < (1 << TBITS); j++) begin
            m = (64'd1 << 30) + (64'(j) << (30 - TBITS));
            r = 0;
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 30;
                r = r << 1;
                if (m >= (64'd1 << 31)) begin
                    r = r | 64'd1;
                    m = m >> 1;
                end
            end
            log_tab[j] = r;
            c  = sqrt_floor(64'd1 << 61);
            mt = 64'd1 << 30;
            for (int k = 1; k <= TBITS; k++) begin
                if (((j >> (TBITS - k)) & 1) != 0)
                    mt = (mt * c) >> 30;
                c = sqrt_floor(c << 30);
            end
            mant_tab[j] = mt;
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_cnt++;
    endtask

    // one sample through the control law, expectation pushed to ctrl_q
    task automatic predict_sample(logic [1:0] act, logic [135:0] w);
        longint p, d, x, prev, raw;
        t_ctrl_word e;
        p = 0;
        d = 0;
        if (act == ACT_LOAD) begin
            integ = lim_clamp(sx32(w[127:96]));
        end else if (act == ACT_CLEAR) begin
            integ = 0;
        end else begin
            if (act == ACT_TRACK) begin
                flt_tgt = first_pending ? sx32(w[31:0])
                                        : lowpass(flt_tgt, sx32(w[31:0]), alphas[15:0]);
                x = sat32(flt_tgt - sx32(w[63:32]));
            end else begin
                flt_tgt = 0;
                x = sx32(w[95:64]);
            end
            if (first_pending) begin
                flt_err = x;
                flt_der = 0;
            end else begin
                prev    = flt_err;
                flt_err = lowpass(flt_err, x, alphas[31:16]);
                if (inv_dt != 0) begin
                    raw     = sat32(mul_fl(flt_err - prev, inv_dt, 16));
                    flt_der = lowpass(flt_der, raw, alphas[47:32]);
                end
            end
            first_pending = 1'b0;
            // anti-windup: while limited only a move toward zero is taken
            if (ki_dt == 0)
                integ = 0;
            else if (!w[128] || (integ > 0 && flt_err < 0) || (integ < 0 && flt_err > 0))
                integ = lim_clamp(integ + mul_fl(flt_err, ki_dt, 28));
            if (act == ACT_TRACK) begin
                p = sat32(mul_fl(fal_fn(flt_err, f_exp[15:0], band), kp, 16));
                d = sat32(mul_fl(fal_fn(flt_der, f_exp[31:16], band), kd, 16));
            end else begin
                p = sat32(mul_fl(flt_err, kp, 16));
                d = sat32(mul_fl(flt_der, kd, 16));
            end
        end
        e.u = 32'(sat32(p + integ + d));
        e.p = 32'(p);
        e.i = 32'(integ);
        e.d = 32'(d);
        ctrl_q.push_back(e);
    endtask

    always @(posedge i_clk) begin
        t_ctrl_word e;
        if (!i_rst_n) begin
            kp = 0; ki_dt = 0; kd = 0; i_lim = 0; f_exp = 0; band = 0; inv_dt = 0;
            alphas = 64'(ALPHA_RESET);
            flt_tgt = 0; flt_err = 0; flt_der = 0; integ = 0;
            first_pending = 1'b1;
            ctrl_q.delete();
            o_fail_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:    kp     = 64'(i_cfg_data[31:0]);
                    CFG_KI:    ki_dt  = 64'(i_cfg_data[31:0]);
                    CFG_KD:    kd     = 64'(i_cfg_data[31:0]);
                    CFG_ILIM:  i_lim  = 64'(i_cfg_data[30:0]);
                    CFG_FEXP:  f_exp  = 64'(i_cfg_data[31:0]);
                    CFG_DELTA: band   = 64'(i_cfg_data[30:0]);
                    CFG_INV:   inv_dt = 64'(i_cfg_data[31:0]);
                    CFG_ALPHA: alphas = 64'(i_cfg_data);
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_sample(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (ctrl_q.size() == 0) begin
                    report("unexpected word", m_axis_tdata[31:0], 32'd0);
                end else begin
                    e = ctrl_q.pop_front();
                    if (m_axis_tdata[31:0] !== e.u) report("control_output", m_axis_tdata[31:0], e.u);
                    if (m_axis_tdata[63:32] !== e.p) report("p_term", m_axis_tdata[63:32], e.p);
                    if (m_axis_tdata[95:64] !== e.i) report("i_term", m_axis_tdata[95:64], e.i);
                    if (m_axis_tdata[127:96] !== e.d) report("d_term", m_axis_tdata[127:96], e.d);
                end
            end
        end
        o_pending = ctrl_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nfpid_pkg::*;

    // cycles without any accepted word before the run is declared hung
    localparam int STALL_LIMIT = 20000;
    // drain margin after the last word, above the slowest item latency
    localparam int DRAIN_CYCLES = 100;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [2:0]    i_cfg_idx;
    logic [47:0]   i_cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // target, measurement, error_in, integrator_value, output_limited, zero pad
    logic [135:0]  s_axis_tdata;
    // action
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // control_output, p_term, i_term, d_term
    logic [127:0]  m_axis_tdata;

    int fail_cnt;
    int pending;
    int quiet_cnt;
    bit no_idle;   // when set, neither side inserts gaps
    bit hold_rx;   // request for one long receiver hold-off

    nonlinear_fal_pid_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    nfpid_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_cnt    (fail_cnt),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: reset or any accepted word restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stall per word, plus one long hold-off on request
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // one register write; the write enable is dropped again before the task returns
    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender: gap drawn per word, valid kept high across back-to-back words
    task automatic send_word(logic [1:0] act, logic [31:0] tgt, logic [31:0] meas,
                             logic [31:0] err, logic [31:0] ival, logic lim);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'd0, lim, ival, err, meas, tgt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // wait for every expected word, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Q16.16 sample value: full range, small, medium or an extreme
    function automatic logic [31:0] rnd_q();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0, 1: return r;
            2:    return {{12{r[19]}}, r[19:0]};
            3:    return {{8{r[23]}}, r[23:0]};
            4:    return {{22{r[9]}}, r[9:0]};
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    3: return 32'hffff_ffff;
                    default: return 32'h0000_0001;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] rnd_gain(int typical_max);
        if ($urandom_range(0, 9) < 2) return $urandom;
        if ($urandom_range(0, 9) == 0) return 32'd0;
        return $urandom_range(0, typical_max);
    endfunction

    function automatic logic [15:0] rnd_exp();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(4000, 20000));
    endfunction

    task automatic random_config();
        logic [47:0] a;
        write_reg(CFG_KP, 48'(rnd_gain(32'h0004_0000)));
        write_reg(CFG_KI, 48'(rnd_gain(32'h0400_0000)));
        write_reg(CFG_KD, 48'(rnd_gain(32'h0002_0000)));
        write_reg(CFG_ILIM, ($urandom_range(0, 3) == 0) ? 48'($urandom & 32'h7fff_ffff)
                                                         : 48'($urandom_range(0, 32'h0100_0000)));
        write_reg(CFG_FEXP, 48'({rnd_exp(), rnd_exp()}));
        write_reg(CFG_DELTA, ($urandom_range(0, 3) == 0) ? 48'($urandom & 32'h7fff_ffff)
                                                          : 48'($urandom_range(0, 32'h0004_0000)));
        write_reg(CFG_INV, ($urandom_range(0, 5) == 0) ? 48'd0
                                                        : 48'(rnd_gain(32'h0064_0000)));
        if ($urandom_range(0, 3) == 0)
            a = {16'($urandom), 16'($urandom), 16'($urandom)};
        else
            a = {16'($urandom_range(0, 16'h8000)), 16'($urandom_range(0, 16'h8000)),
                 16'($urandom_range(0, 16'h8000))};
        write_reg(CFG_ALPHA, a);
    endtask

    // half tracking samples around a slowly moving target, some noise; the rest error, load or clear
    task automatic random_words(int n);
        logic [31:0] tgt;
        logic [31:0] r;
        int pick;
        tgt = rnd_q();
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            r = $urandom;
            if (pick < 5) begin
                if ($urandom_range(0, 7) == 0) tgt = rnd_q();
                else tgt = tgt + {{20{r[11]}}, r[11:0]};
                send_word(ACT_TRACK, tgt, ($urandom_range(0, 2) == 0) ? rnd_q()
                          : tgt + {{16{r[31]}}, r[31:16]}, rnd_q(), rnd_q(), r[12]);
            end else if (pick < 8) begin
                send_word(ACT_ERROR, rnd_q(), rnd_q(), rnd_q(), rnd_q(), r[13]);
            end else if (pick == 8) begin
                send_word(ACT_LOAD, rnd_q(), rnd_q(), rnd_q(), rnd_q(), r[14]);
            end else begin
                send_word(ACT_CLEAR, rnd_q(), rnd_q(), rnd_q(), rnd_q(), r[15]);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_TRACK;
        no_idle       = 1'b0;
        hold_rx       = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: first sample loads filters, gains all zero
        send_word(ACT_TRACK, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
        send_word(ACT_TRACK, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
        drain();

        // moderate gains, sub-linear fal exponents
        write_reg(CFG_KP, 48'h0001_0000);
        write_reg(CFG_KI, 48'h0100_0000);
        write_reg(CFG_KD, 48'h0000_8000);
        write_reg(CFG_ILIM, 48'h0064_0000);
        write_reg(CFG_FEXP, {16'd0, 16'd12288, 16'd8192});
        write_reg(CFG_DELTA, 48'h0001_0000);
        write_reg(CFG_INV, 48'h0064_0000);
        write_reg(CFG_ALPHA, 48'h4000_6000_2000);
        // target equal to the measurement, then a gap inside and one outside the linear band
        send_word(ACT_TRACK, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b0);
        send_word(ACT_TRACK, 32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0, 1'b0);
        send_word(ACT_TRACK, 32'h0010_0000, 32'hfff0_0000, 32'h0, 32'h0, 1'b0);
        // error update with extremes, linear P and D
        send_word(ACT_ERROR, 32'h1234_5678, 32'h0, 32'h7fff_ffff, 32'h0, 1'b0);
        send_word(ACT_ERROR, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 1'b0);
        // integrator load beyond the clamp, both signs, then clear
        send_word(ACT_LOAD, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 1'b0);
        send_word(ACT_TRACK, 32'h0100_0000, 32'h0, 32'h0, 32'h0, 1'b1);  // limited, growing
        send_word(ACT_TRACK, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 1'b1);  // limited, shrinking
        send_word(ACT_LOAD, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b1);
        send_word(ACT_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_word(ACT_ERROR, 32'h0, 32'h0, 32'hffff_ffff, 32'h0, 1'b1);
        drain();

        // every register at its top value, alpha above one
        write_reg(CFG_KP, 48'hffff_ffff);
        write_reg(CFG_KI, 48'hffff_ffff);
        write_reg(CFG_KD, 48'hffff_ffff);
        write_reg(CFG_ILIM, 48'h7fff_ffff);
        write_reg(CFG_FEXP, 48'hffff_ffff);
        write_reg(CFG_DELTA, 48'h7fff_ffff);
        write_reg(CFG_INV, 48'hffff_ffff);
        write_reg(CFG_ALPHA, 48'hffff_ffff_ffff);
        send_word(ACT_TRACK, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
        send_word(ACT_TRACK, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
        send_word(ACT_ERROR, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 1'b0);
        send_word(ACT_TRACK, 32'h0000_0003, 32'h0, 32'h0, 32'h0, 1'b1);
        drain();

        // zero ki, zero inverse step, zero band and exponents
        write_reg(CFG_KI, 48'd0);
        write_reg(CFG_INV, 48'd0);
        write_reg(CFG_DELTA, 48'd0);
        write_reg(CFG_FEXP, 48'd0);
        write_reg(CFG_ALPHA, 48'h0000_0001_0000);
        send_word(ACT_TRACK, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 1'b0);
        send_word(ACT_TRACK, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_word(ACT_ERROR, 32'h0, 32'h0, 32'hfffe_0000, 32'h0, 1'b0);
        send_word(ACT_LOAD, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 1'b0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            random_config();
            no_idle = (ph == 2 || ph == 6);
            if (ph == 4) hold_rx = 1'b1;  // receiver backs up while words keep coming
            random_words(113);
            drain();
        end

        if (fail_cnt == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
sv/nfpid_pkg.sv
sv/nfpid_ctrl.sv
sv/nfpid_datapath.sv
sv/nonlinear_fal_pid_controller.sv
tb/nfpid_checker.sv
tb/tb_top.sv
